[src/sha1_hash_engine_assert.svh]
// assertion macros shared by the sha1 engine rtl
// depends on nothing; included by the top level
`ifndef SHA1_HASH_ENGINE_ASSERT_SVH
`define SHA1_HASH_ENGINE_ASSERT_SVH
// implication checked every clock outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define SHA_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

[src/sha1_pkg.sv]
// sha1 package: constants, state enum and round helpers
// no dependencies
`default_nettype none
package sha1_pkg;
  localparam logic [31:0] IV0 = 32'h67452301;
  localparam logic [31:0] IV1 = 32'hEFCDAB89;
  localparam logic [31:0] IV2 = 32'h98BADCFE;
  localparam logic [31:0] IV3 = 32'h10325476;
  localparam logic [31:0] IV4 = 32'hC3D2E1F0;
  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;
  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic FUNC_ABSORB = 1'b0;
  localparam logic FUNC_FINISH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_LOAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_t;

  function automatic logic [31:0] iv_word(input logic [2:0] i);
    case (i)
      3'd0: iv_word = IV0;
      3'd1: iv_word = IV1;
      3'd2: iv_word = IV2;
      3'd3: iv_word = IV3;
      default: iv_word = IV4;
    endcase
  endfunction

  function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                          input logic [31:0] c, input logic [31:0] d);
    if (t < 7'd20) round_f = (b & c) | (~b & d);
    else if (t < 7'd40) round_f = b ^ c ^ d;
    else if (t < 7'd60) round_f = (b & c) | (b & d) | (c & d);
    else round_f = b ^ c ^ d;
  endfunction

  function automatic logic [31:0] round_k(input logic [6:0] t);
    if (t < 7'd20) round_k = K0;
    else if (t < 7'd40) round_k = K1;
    else if (t < 7'd60) round_k = K2;
    else round_k = K3;
  endfunction
endpackage
`default_nettype wire

[src/sha1_hash_engine.sv]
// sha1_hash_engine: streaming SHA-1 hasher, top level
// depends on sha1_pkg and sha1_hash_engine_assert.svh
//
// usage:
//  - input channel in_valid/in_stall carries in_func and in_data_byte. an absorb
//    transfer stores one byte; a finish transfer pads the message and emits the
//    digest. a transfer completes when valid is high and stall is low.
//  - result channel out_valid/out_stall carries five digest words, index 0..4,
//    the fifth with out_last_word set. out_valid holds with its payload while
//    out_stall is high; the engine waits in the emit phase until each is taken.
//  - the message schedule lives in a 16 x 32 memory with a registered read;
//    each round reads w[t-3], w[t-8], w[t-14], w[t] one after another and
//    writes the new w back, as there is only one memory read port.
//  - an absorb byte is stored without stalling except the 64th, which starts
//    compression: a load step, 80 rounds and a fold, with in_stall high throughout.
//  - finish: padding up to 64 bytes, one or two compressions, then 5 word
//    transfers.
//  - one item at a time; in_stall is high whenever the engine is busy.
//  - reset loads the standard initial chaining values and clears the count;
//    after a digest the engine returns to that same state.
`default_nettype none
module sha1_hash_engine import sha1_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_func,
  input  wire logic [7:0]  in_data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  // schedule memory, one write and one registered read per cycle
  logic [31:0] wmem [16];
  logic        we;
  logic [3:0]  waddr, raddr;
  logic [31:0] wdata, rdata_r;

  always_ff @(posedge clk) begin
    if (we) wmem[waddr] <= wdata;
    rdata_r <= wmem[raddr];
  end

  state_t state_r, state_nxt;
  logic [60:0] cnt_r;
  logic [31:0] word_r;         // byte packing register
  logic [31:0] cv_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [6:0]  t_r;            // round number
  logic [1:0]  ph_r;           // phase within a round
  logic [31:0] x_r;            // schedule xor accumulator
  logic        fin_r;          // compressing for a finish
  logic        two_r;          // finish needs a second block
  logic [63:0] bits_r;         // latched bit length
  logic [5:0]  pidx_r;         // padding byte index
  logic [2:0]  oi_r;

  wire in_xfer  = in_valid && !in_stall;
  wire out_xfer = out_valid && !out_stall;
  wire [5:0] idx = cnt_r[5:0];

  // byte written during pad phase; the 0x80 marker sits at the count position
  // of the first pad block, the length field ends the last one
  logic [7:0] pad_b;
  always_comb begin
    if (pidx_r >= 6'd56 && !two_r) pad_b = bits_r[8'd63 - {2'b0, pidx_r[2:0], 3'b0} -: 8];
    else if (pidx_r == idx) pad_b = PAD_BYTE;
    else pad_b = 8'h00;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_xfer) begin
        if (in_func == FUNC_FINISH) state_nxt = ST_PAD;
        else if (idx == 6'd63) state_nxt = ST_LOAD;
      end
      ST_PAD: if (pidx_r == 6'd63) state_nxt = ST_ROUND;
      ST_LOAD: state_nxt = ST_ROUND;
      ST_ROUND: if (t_r == 7'd79 && ph_r == 2'd3) state_nxt = ST_FOLD;
      ST_FOLD: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (two_r) state_nxt = ST_PAD;
        else state_nxt = ST_EMIT;
      end
      ST_EMIT: if (out_xfer && oi_r == 3'd4) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = (state_r != ST_IDLE);
    out_valid = (state_r == ST_EMIT);
  end

  assign out_digest_word = cv_r[oi_r];
  assign out_word_index  = oi_r;
  assign out_last_word   = (oi_r == 3'd4);

  // round datapath; phases 0..2 issue w[t-8], w[t-14], w[t], phase 3 issues
  // w[t-3] of the next round, so phase 3 sees w[t] with the xor of the others
  logic [3:0] t4;
  assign t4 = t_r[3:0];
  always_comb begin
    case (ph_r)
      2'd0: raddr = t4 - 4'd8;
      2'd1: raddr = t4 - 4'd14;
      2'd2: raddr = t4;
      default: raddr = t4 - 4'd2;
    endcase
  end

  logic [31:0] wt, wnew, sum;
  always_comb begin
    wnew = x_r ^ rdata_r;
    wnew = {wnew[30:0], wnew[31]};
    wt = (t_r < 7'd16) ? rdata_r : wnew;
    sum = {a_r[26:0], a_r[31:27]} + round_f(t_r, b_r, c_r, d_r) + e_r
          + round_k(t_r) + wt;
  end

  // memory write port
  always_comb begin
    we = 1'b0;
    waddr = idx[5:2];
    wdata = {word_r[23:0], in_data_byte};
    if (state_r == ST_IDLE && in_xfer && in_func == FUNC_ABSORB) begin
      we = (idx[1:0] == 2'd3);
    end else if (state_r == ST_PAD) begin
      waddr = pidx_r[5:2];
      wdata = {word_r[23:0], pad_b};
      we = (pidx_r[1:0] == 2'd3);
    end else if (state_r == ST_ROUND && ph_r == 2'd3 && t_r >= 7'd16) begin
      waddr = t4;
      wdata = wnew;
      we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r <= '0;
      fin_r <= 1'b0;
      two_r <= 1'b0;
      oi_r <= '0;
      t_r <= '0;
      ph_r <= '0;
      pidx_r <= '0;
      for (int i = 0; i < 5; i++) cv_r[i] <= iv_word(3'(i));
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: if (in_xfer) begin
          if (in_func == FUNC_ABSORB) begin
            word_r <= {word_r[23:0], in_data_byte};
            cnt_r <= cnt_r + 61'd1;
            fin_r <= 1'b0;
          end else begin
            bits_r <= {cnt_r, 3'b000};
            fin_r <= 1'b1;
            two_r <= (idx >= 6'd56);
            pidx_r <= idx;
            word_r <= (idx[1:0] == 2'd0) ? 32'h0 : word_r;
          end
          t_r <= '0;
          ph_r <= '0;
        end
        ST_PAD: begin
          word_r <= {word_r[23:0], pad_b};
          pidx_r <= pidx_r + 6'd1;
          if (pidx_r == 6'd63) begin
            a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2];
            d_r <= cv_r[3]; e_r <= cv_r[4];
          end
        end
        ST_LOAD: begin
          a_r <= cv_r[0]; b_r <= cv_r[1]; c_r <= cv_r[2];
          d_r <= cv_r[3]; e_r <= cv_r[4];
        end
        ST_ROUND: begin
          ph_r <= ph_r + 2'd1;
          if (ph_r == 2'd0) x_r <= rdata_r;
          else if (ph_r != 2'd3) x_r <= x_r ^ rdata_r;
          if (ph_r == 2'd3) begin
            e_r <= d_r; d_r <= c_r; c_r <= {b_r[1:0], b_r[31:2]};
            b_r <= a_r; a_r <= sum;
            t_r <= t_r + 7'd1;
          end
        end
        ST_FOLD: begin
          cv_r[0] <= cv_r[0] + a_r; cv_r[1] <= cv_r[1] + b_r;
          cv_r[2] <= cv_r[2] + c_r; cv_r[3] <= cv_r[3] + d_r;
          cv_r[4] <= cv_r[4] + e_r;
          t_r <= '0;
          ph_r <= '0;
          if (two_r) begin
            two_r <= 1'b0;
            fin_r <= 1'b1;
            pidx_r <= '0;
          end
          oi_r <= '0;
        end
        ST_EMIT: if (out_xfer) begin
          oi_r <= oi_r + 3'd1;
          if (oi_r == 3'd4) begin
            for (int i = 0; i < 5; i++) cv_r[i] <= iv_word(3'(i));
            cnt_r <= '0;
            fin_r <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  `include "sha1_hash_engine_assert.svh"
  `SHA_ASSERT_IMP(a_stall_busy, state_r != ST_IDLE, in_stall)
  `SHA_ASSERT_IMP(a_out_emit, out_valid, state_r == ST_EMIT && oi_r <= 3'd4)
  `SHA_ASSERT_NXT(a_hold, out_valid && out_stall, out_valid && $stable(out_word_index))
  `SHA_ASSERT_NXT(a_last_idle, out_xfer && out_last_word, state_r == ST_IDLE && cnt_r == '0)
endmodule
`default_nettype wire

[tb/sv/tb_sha1_hash_engine.sv]
// testbench for sha1_hash_engine: streams message bytes and finish items,
// predicts each digest with a local sha-1 model and checks every word
// depends on sha1_pkg and the sha1_hash_engine rtl
`default_nettype none
module tb_sha1_hash_engine;
  import sha1_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_word_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic        in_func;
  logic [7:0]  in_data_byte;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sha1_hash_engine dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_func(in_func), .in_data_byte(in_data_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_digest_word(out_digest_word), .out_word_index(out_word_index),
    .out_last_word(out_last_word)
  );

  // predictor state
  logic [31:0] chain_q [5];
  logic [7:0]  blk_q [64];
  logic [60:0] nbytes_q;
  digest_word_t digest_fifo [$];

  int unsigned mismatches;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;
  longint unsigned cycle_cnt;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [31:0] rotl32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // one 80-round compression of blk_q into chain_q
  task automatic sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, sum;
    for (int t = 0; t < 16; t++)
      w[t] = {blk_q[4*t], blk_q[4*t+1], blk_q[4*t+2], blk_q[4*t+3]};
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3]; e = chain_q[4];
    for (int t = 0; t < 80; t++) begin
      if (t >= 16)
        w[t%16] = rotl32(w[(t-3)%16] ^ w[(t-8)%16] ^ w[(t-14)%16] ^ w[t%16], 1);
      if (t < 20) begin
        f = (b & c) | (~b & d); k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d; k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d); k = K2;
      end else begin
        f = b ^ c ^ d; k = K3;
      end
      sum = rotl32(a, 5) + f + e + k + w[t%16];
      e = d; d = c; c = rotl32(b, 30); b = a; a = sum;
    end
    chain_q[0] += a; chain_q[1] += b; chain_q[2] += c; chain_q[3] += d; chain_q[4] += e;
  endtask

  task automatic sha1_restart();
    chain_q[0] = IV0; chain_q[1] = IV1; chain_q[2] = IV2;
    chain_q[3] = IV3; chain_q[4] = IV4;
    nbytes_q = '0;
  endtask

  // apply one accepted item to the predictor, queueing digest words on finish
  task automatic sha1_predict(logic func, logic [7:0] data);
    int unsigned pos;
    logic [63:0] bits;
    digest_word_t dw;
    pos = nbytes_q[5:0];
    if (func == FUNC_ABSORB) begin
      blk_q[pos] = data;
      nbytes_q = nbytes_q + 61'd1;
      if (pos == 63) sha1_compress();
    end else begin
      bits = {nbytes_q, 3'b000};
      blk_q[pos] = PAD_BYTE;
      for (int i = pos + 1; i < 64; i++) blk_q[i] = 8'h00;
      if (pos >= 56) begin
        sha1_compress();
        for (int i = 0; i < 64; i++) blk_q[i] = 8'h00;
      end
      for (int i = 0; i < 8; i++) blk_q[56+i] = bits[63-8*i -: 8];
      sha1_compress();
      for (int i = 0; i < 5; i++) begin
        dw.word = chain_q[i];
        dw.index = 3'(i);
        dw.last = (i == 4);
        digest_fifo.push_back(dw);
      end
      sha1_restart();
    end
  endtask

  // one transfer on the input channel, sender idles at random first
  task automatic send_item(logic func, logic [7:0] data);
    while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= func;
    in_data_byte <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sha1_predict(func, data);
  endtask

  task automatic send_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(FUNC_ABSORB, 8'($urandom));
    send_item(FUNC_FINISH, 8'($urandom));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver: random stall, plus a long hold-off when requested
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_cycles != 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
    end
  end

  // check every digest word transfer against the oldest prediction
  always @(posedge clk) begin
    digest_word_t exp_w;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_fifo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected digest word %h idx %0d", out_digest_word, out_word_index);
      end else begin
        exp_w = digest_fifo.pop_front();
        if (exp_w.word !== out_digest_word || exp_w.index !== out_word_index ||
            exp_w.last !== out_last_word) begin
          mismatches++;
          if (mismatches <= 10)
            $display("digest word: expected %h/%0d/%b got %h/%0d/%b",
                     exp_w.word, exp_w.index, exp_w.last,
                     out_digest_word, out_word_index, out_last_word);
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > 64'd6_000_000) begin
      $display("sha1_hash_engine: mismatch");
      $finish;
    end
  end

  // empty message, a single zero byte, and a three-byte message
  task automatic test_directed();
    send_item(FUNC_FINISH, 8'hFF);
    send_item(FUNC_ABSORB, 8'h00);
    send_item(FUNC_FINISH, 8'h00);
    send_item(FUNC_ABSORB, 8'hFF);
    send_item(FUNC_ABSORB, 8'hAA);
    send_item(FUNC_ABSORB, 8'h55);
    send_item(FUNC_FINISH, 8'h00);
    drain();
  endtask

  // lengths that land the pad byte near the length field and block edges
  task automatic test_pad_boundaries();
    int unsigned lens [4] = '{55, 56, 63, 64};
    foreach (lens[i]) send_message(lens[i]);
    drain();
  endtask

  // random messages under each idling mix, mostly short
  task automatic test_random(int unsigned sidle, int unsigned rstall, int unsigned budget);
    int unsigned sent;
    int unsigned len;
    send_idle_pct = sidle;
    recv_stall_pct = rstall;
    sent = 0;
    while (sent < budget) begin
      len = ($urandom_range(9, 0) == 0) ? $urandom_range(70, 50) : $urandom_range(20, 0);
      send_message(len);
      sent += len + 1;
    end
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
  endtask

  // receiver holds off long while finishes keep coming, so the engine backs up
  task automatic test_backpressure();
    hold_cycles = 3000;
    send_message(3);
    send_message(0);
    send_message(1);
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ABSORB;
    in_data_byte = 8'h00;
    out_stall = 1'b0;
    mismatches = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 0;
    cycle_cnt = 0;
    for (int i = 0; i < 64; i++) blk_q[i] = 8'h00;
    sha1_restart();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_pad_boundaries();
    test_backpressure();
    test_random(0, 0, 25);
    test_random(47, 0, 25);
    test_random(0, 47, 25);
    test_random(26, 26, 25);
    if (digest_fifo.size() == 0 && mismatches == 0)
      $display("sha1_hash_engine: match");
    else
      $display("sha1_hash_engine: mismatch");
    $finish;
  end
endmodule
`default_nettype wire

[sha1_hash_engine.f]
+incdir+src
src/sha1_pkg.sv
src/sha1_hash_engine.sv
tb/sv/tb_sha1_hash_engine.sv
